@@ rtl/ppsp_pkg.sv @@
// Shared types and constants for the PPM stream parser.
// Holds the classified byte record, the result record, character, kind and error codes.
// No dependencies.
package ppsp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  localparam int unsigned MAXVAL     = 255;
  localparam int unsigned COUNT_BITS = 34;
  localparam int unsigned PROD_BITS  = 32;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_EARLY_END = 3'd1;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd2;
  localparam logic [2:0] ERR_NO_MAGIC  = 3'd3;
  localparam logic [2:0] ERR_MAXVAL    = 3'd4;
  localparam logic [2:0] ERR_TOO_BIG   = 3'd5;
  localparam logic [2:0] ERR_PIXEL     = 3'd6;

  // One input byte after classification.
  typedef struct packed {
    logic       end_mark;
    logic [7:0] raw;
    logic [3:0] digit;
    logic       is_digit;
    logic       is_ws;
    logic       is_eol;
    logic       is_hash;
    logic       is_p;
    logic       is_three;
    logic       is_six;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  component;
    logic [15:0] image_cols;
    logic [15:0] image_rows;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

endpackage

@@ rtl/ppsp_front.sv @@
// Front end: takes file bytes from the input stream and classifies them.
// Pushes one classified record per transaction into the queue. Uses ppsp_pkg.
module ppsp_front import ppsp_pkg::*; (
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // file_byte
  input  logic       s_tlast,   // end_mark
  input  logic       queue_full,
  output logic       push,
  output item_t      push_item
);

  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  always_comb begin
    push_item          = '0;
    push_item.end_mark = s_tlast;
    push_item.raw      = s_tdata;
    push_item.digit    = s_tdata[3:0];
    push_item.is_digit = s_tdata inside {[CH_0:CH_9]};
    push_item.is_ws    = (s_tdata == CH_SP) || (s_tdata inside {[CH_TAB:CH_CR]});
    push_item.is_eol   = (s_tdata == CH_LF) || (s_tdata == CH_CR);
    push_item.is_hash  = (s_tdata == CH_HASH);
    push_item.is_p     = (s_tdata == CH_P);
    push_item.is_three = (s_tdata == CH_3);
    push_item.is_six   = (s_tdata == CH_6);
  end

endmodule

@@ rtl/ppsp_queue.sv @@
// Short queue of classified bytes between front end and parser.
// Simultaneous push and pop are allowed. Uses ppsp_pkg.
module ppsp_queue import ppsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  not_empty,
  input  logic  pop,
  output item_t head
);

  item_t                store [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  // reads as full during reset so no transaction is taken then
  assign full      = rst || (count == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/ppsp_back.sv @@
// Back end: PPM header and pixel parser working on classified bytes,
// with the registered result stage. Uses ppsp_pkg.
module ppsp_back import ppsp_pkg::*; #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  output logic    pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef enum logic [5:0] {
    PH_MAGIC_P = 6'b000001,
    PH_MAGIC_D = 6'b000010,
    PH_HEADER  = 6'b000100,
    PH_RAW     = 6'b001000,
    PH_PLAIN   = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  localparam int unsigned NUM_W = DIM_BITS + 4;
  localparam int unsigned EXT_W = DIM_BITS + 16;

  phase_t                phase, phase_next;
  logic                  raw_format, raw_format_next;
  logic [DIM_BITS-1:0]   number_value, number_value_next;
  logic                  digits_seen, digits_seen_next;
  logic                  in_comment, in_comment_next;
  logic [1:0]            fields_read, fields_read_next;
  logic [15:0]           cols_reg, cols_reg_next;
  logic [15:0]           rows_reg, rows_reg_next;
  logic [COUNT_BITS-1:0] components_left, components_left_next;
  logic [PROD_BITS-1:0]  prod;

  logic                  emit;
  result_t               emit_res;
  logic [NUM_W-1:0]      acc;
  logic                  acc_over;
  logic [EXT_W-1:0]      num_ext;
  logic                  num_is_max;
  logic                  num_over_byte;
  logic                  last_comp;

  function automatic result_t mk_fail(input logic [2:0] code);
    result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic result_t mk_comp(input logic [7:0] v, input logic lst);
    result_t r;
    r           = '0;
    r.kind      = KIND_PIXEL;
    r.component = v;
    r.last      = lst;
    return r;
  endfunction

  function automatic result_t mk_hdr(input logic [15:0] c, input logic [15:0] w,
                                     input logic lst);
    result_t r;
    r            = '0;
    r.kind       = KIND_HEADER;
    r.image_cols = c;
    r.image_rows = w;
    r.last       = lst;
    return r;
  endfunction

  assign pop = item_valid && (!res_valid || res_ready);

  // x10 as shift-add; the value never exceeds the dimension limit once stored
  assign acc = ({4'b0, number_value} << 3) + ({4'b0, number_value} << 1)
             + NUM_W'(item.digit);
  assign acc_over      = (acc[NUM_W-1:DIM_BITS] != '0);
  assign num_ext       = {16'b0, number_value};
  assign num_is_max    = (num_ext == EXT_W'(MAXVAL));
  assign num_over_byte = (num_ext > EXT_W'(MAXVAL));
  assign last_comp     = (components_left == COUNT_BITS'(1));

  always_comb begin
    phase_next           = phase;
    raw_format_next      = raw_format;
    number_value_next    = number_value;
    digits_seen_next     = digits_seen;
    in_comment_next      = in_comment;
    fields_read_next     = fields_read;
    cols_reg_next        = cols_reg;
    rows_reg_next        = rows_reg;
    components_left_next = components_left;
    emit                 = 1'b0;
    emit_res             = '0;

    if (pop) begin
      if (item.end_mark) begin
        case (phase)
          PH_DONE: ;
          PH_HEADER: begin
            emit = 1'b1;
            if (!in_comment && digits_seen && fields_read == 2'd2) begin
              if (!num_is_max) begin
                emit_res = mk_fail(ERR_MAXVAL);
              end else if (cols_reg == '0 || rows_reg == '0) begin
                emit_res = mk_hdr(cols_reg, rows_reg, 1'b1);
              end else begin
                emit_res = mk_fail(ERR_EARLY_END);
              end
            end else begin
              emit_res = mk_fail(ERR_EARLY_END);
            end
          end
          PH_PLAIN: begin
            emit = 1'b1;
            if (digits_seen && last_comp) begin
              if (num_over_byte) begin
                emit_res = mk_fail(ERR_PIXEL);
              end else begin
                emit_res = mk_comp(number_value[7:0], 1'b1);
              end
            end else begin
              emit_res = mk_fail(ERR_EARLY_END);
            end
          end
          default: begin
            emit     = 1'b1;
            emit_res = mk_fail(ERR_EARLY_END);
          end
        endcase
        // rearm for the next file
        phase_next           = PH_MAGIC_P;
        raw_format_next      = 1'b0;
        number_value_next    = '0;
        digits_seen_next     = 1'b0;
        in_comment_next      = 1'b0;
        fields_read_next     = '0;
        cols_reg_next        = '0;
        rows_reg_next        = '0;
        components_left_next = '0;
      end else begin
        case (phase)
          PH_MAGIC_P: begin
            if (item.is_p) begin
              phase_next = PH_MAGIC_D;
            end else begin
              emit       = 1'b1;
              emit_res   = mk_fail(ERR_NO_MAGIC);
              phase_next = PH_DONE;
            end
          end
          PH_MAGIC_D: begin
            if (item.is_three || item.is_six) begin
              raw_format_next = item.is_six;
              phase_next      = PH_HEADER;
            end else begin
              emit       = 1'b1;
              emit_res   = mk_fail(ERR_NO_MAGIC);
              phase_next = PH_DONE;
            end
          end
          PH_HEADER: begin
            logic done_num;
            done_num = 1'b0;
            if (in_comment) begin
              if (item.is_eol) begin
                in_comment_next = 1'b0;
                done_num        = digits_seen;
              end
            end else if (item.is_hash) begin
              in_comment_next = 1'b1;
            end else if (item.is_digit) begin
              digits_seen_next  = 1'b1;
              number_value_next = acc[DIM_BITS-1:0];
              if (acc_over) begin
                emit       = 1'b1;
                emit_res   = mk_fail(ERR_TOO_BIG);
                phase_next = PH_DONE;
              end
            end else if (item.is_ws) begin
              done_num = digits_seen;
            end else begin
              emit       = 1'b1;
              emit_res   = mk_fail(ERR_BAD_CHAR);
              phase_next = PH_DONE;
            end

            if (done_num) begin
              number_value_next = '0;
              digits_seen_next  = 1'b0;
              if (fields_read == 2'd0) begin
                cols_reg_next    = num_ext[15:0];
                fields_read_next = 2'd1;
              end else if (fields_read == 2'd1) begin
                rows_reg_next    = num_ext[15:0];
                fields_read_next = 2'd2;
              end else begin
                emit = 1'b1;
                if (!num_is_max) begin
                  emit_res   = mk_fail(ERR_MAXVAL);
                  phase_next = PH_DONE;
                end else begin
                  // prod holds cols*rows since at least one byte ago
                  components_left_next = {1'b0, prod, 1'b0} + {2'b0, prod};
                  if (cols_reg == '0 || rows_reg == '0) begin
                    emit_res   = mk_hdr(cols_reg, rows_reg, 1'b1);
                    phase_next = PH_DONE;
                  end else begin
                    emit_res   = mk_hdr(cols_reg, rows_reg, 1'b0);
                    phase_next = raw_format ? PH_RAW : PH_PLAIN;
                  end
                end
              end
            end
          end
          PH_RAW: begin
            emit                 = 1'b1;
            emit_res             = mk_comp(item.raw, last_comp);
            components_left_next = components_left - 1'b1;
            if (last_comp) begin
              phase_next = PH_DONE;
            end
          end
          PH_PLAIN: begin
            if (item.is_digit) begin
              digits_seen_next  = 1'b1;
              number_value_next = acc[DIM_BITS-1:0];
              if (acc_over) begin
                emit       = 1'b1;
                emit_res   = mk_fail(ERR_PIXEL);
                phase_next = PH_DONE;
              end
            end else if (item.is_ws) begin
              if (digits_seen) begin
                number_value_next = '0;
                digits_seen_next  = 1'b0;
                emit              = 1'b1;
                if (num_over_byte) begin
                  emit_res   = mk_fail(ERR_PIXEL);
                  phase_next = PH_DONE;
                end else begin
                  emit_res             = mk_comp(number_value[7:0], last_comp);
                  components_left_next = components_left - 1'b1;
                  if (last_comp) begin
                    phase_next = PH_DONE;
                  end
                end
              end
            end else begin
              emit       = 1'b1;
              emit_res   = mk_fail(ERR_BAD_CHAR);
              phase_next = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_BITS'(cols_reg) * PROD_BITS'(rows_reg);
    if (pop && emit) begin
      res <= emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MAGIC_P;
      raw_format      <= 1'b0;
      number_value    <= '0;
      digits_seen     <= 1'b0;
      in_comment      <= 1'b0;
      fields_read     <= '0;
      cols_reg        <= '0;
      rows_reg        <= '0;
      components_left <= '0;
      res_valid       <= 1'b0;
    end else begin
      phase           <= phase_next;
      raw_format      <= raw_format_next;
      number_value    <= number_value_next;
      digits_seen     <= digits_seen_next;
      in_comment      <= in_comment_next;
      fields_read     <= fields_read_next;
      cols_reg        <= cols_reg_next;
      rows_reg        <= rows_reg_next;
      components_left <= components_left_next;
      if (pop && emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/ppm_stream_parser_unit.sv @@
// PPM (P3/P6) stream parser, top level.
// Front end classifier, a two-entry queue and the parser back end.
// Uses ppsp_pkg, ppsp_front, ppsp_queue, ppsp_back.
//
// Usage: feed the file one byte per input transaction on s_tdata. Assert
// s_tlast on an extra transaction after the last byte to end the file; its
// data is ignored and the parser rearms for the next file.
// Results come out on the m_ group: m_tuser is the kind (pixel component,
// header, error), m_tdata carries component, width, height and error code,
// m_tlast marks the final result of a file.
// Throughput: one byte per cycle, sustained, while the output is taken.
// A result is registered: the byte that causes it passes through the queue
// and then the result register.
// The parser works one byte per cycle unless a result waits untaken; pixel
// count comes from a registered width*height product, so the maxval can end
// no sooner than one byte after the height, which the file format guarantees.
// Reset: synchronous, clears the queue, the parser and the result valid flag.
// Stall: when m_tready is low the result is held; the queue fills and then
// s_tready drops until the result is taken.
module ppm_stream_parser_unit import ppsp_pkg::*; #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] file_byte
  input  logic        s_tlast,   // end_mark
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] component, [23:8] image_cols,
                                 // [39:24] image_rows, [42:40] error_code, rest 0
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // last
);

  logic    queue_full;
  logic    push;
  item_t   push_item;
  logic    not_empty;
  logic    pop;
  item_t   head;
  result_t res;

  ppsp_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  ppsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .not_empty (not_empty),
    .pop       (pop),
    .head      (head)
  );

  ppsp_back #(
    .DIM_BITS (DIM_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (not_empty),
    .item       (head),
    .pop        (pop),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {5'b0, res.error_code, res.image_rows, res.image_cols, res.component};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

@@ bench/ppm_stream_parser_unit_tb.sv @@
// Self-checking bench for ppm_stream_parser_unit: byte-stream PPM files in, results out.
// A scoreboard class predicts every result and checks the output stream field by field.
// Depends on ppsp_pkg and the ppm_stream_parser_unit RTL.
module ppm_stream_parser_unit_tb;
  import ppsp_pkg::*;

  localparam int unsigned DIM_BITS     = 16;
  localparam logic [63:0] DIM_MAX      = (64'd1 << DIM_BITS) - 64'd1;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam logic [7:0]  CH_VT        = 8'h0B;
  localparam logic [7:0]  CH_FF        = 8'h0C;

  typedef enum logic [2:0] {
    WANT_P, WANT_FORMAT, IN_HEADER, RAW_DATA, PLAIN_DATA, FILE_DONE
  } parse_phase_t;

  class parse_scoreboard;
    parse_phase_t phase;
    logic         raw_fmt;
    logic [63:0]  num;
    logic         have_digits;
    logic         in_cmt;
    int unsigned  fields_read;
    logic [15:0]  cols;
    logic [15:0]  rows;
    logic [33:0]  comps_left;
    result_t      results_due[$];
    int unsigned  errors;

    function new();
      errors = 0;
      rearm();
    endfunction

    function void rearm();
      phase       = WANT_P;
      raw_fmt     = 1'b0;
      num         = '0;
      have_digits = 1'b0;
      in_cmt      = 1'b0;
      fields_read = 0;
      cols        = '0;
      rows        = '0;
      comps_left  = '0;
    endfunction

    function bit is_num(logic [7:0] b);
      return b >= CH_0 && b <= CH_9;
    endfunction

    function bit is_blank(logic [7:0] b);
      return b == CH_SP || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function void queue_result(logic [1:0] kind, logic [7:0] comp, logic [15:0] c,
                               logic [15:0] r, logic [2:0] code, logic lst);
      result_t res;
      res.kind       = kind;
      res.component  = comp;
      res.image_cols = c;
      res.image_rows = r;
      res.error_code = code;
      res.last       = lst;
      results_due.push_back(res);
    endfunction

    function void fail(logic [2:0] code);
      phase = FILE_DONE;
      queue_result(KIND_ERROR, 8'd0, 16'd0, 16'd0, code, 1'b1);
    endfunction

    function void give_component(logic [7:0] v);
      comps_left = comps_left - 34'd1;
      if (comps_left == 0) phase = FILE_DONE;
      queue_result(KIND_PIXEL, v, 16'd0, 16'd0, ERR_NONE, comps_left == 0);
    endfunction

    function void close_header_number();
      logic [63:0] v;
      v = num;
      num = '0;
      have_digits = 1'b0;
      if (fields_read == 0) begin
        cols = v[15:0];
        fields_read = 1;
      end else if (fields_read == 1) begin
        rows = v[15:0];
        fields_read = 2;
      end else if (v != MAXVAL) begin
        fail(ERR_MAXVAL);
      end else begin
        comps_left = 34'd3 * cols * rows;
        if (comps_left == 0) begin
          phase = FILE_DONE;
          queue_result(KIND_HEADER, 8'd0, cols, rows, ERR_NONE, 1'b1);
        end else begin
          phase = raw_fmt ? RAW_DATA : PLAIN_DATA;
          queue_result(KIND_HEADER, 8'd0, cols, rows, ERR_NONE, 1'b0);
        end
      end
    endfunction

    // One accepted input transaction.
    function void note_byte(logic [7:0] b, logic eom);
      logic [63:0] v;
      if (eom) begin
        case (phase)
          FILE_DONE: ;
          IN_HEADER: begin
            // a pending maxval may still complete the header of an empty image
            if (!in_cmt && have_digits && fields_read == 2) begin
              if (num != MAXVAL) fail(ERR_MAXVAL);
              else if (cols == 0 || rows == 0)
                queue_result(KIND_HEADER, 8'd0, cols, rows, ERR_NONE, 1'b1);
              else fail(ERR_EARLY_END);
            end else begin
              fail(ERR_EARLY_END);
            end
          end
          PLAIN_DATA: begin
            if (have_digits && comps_left == 1) begin
              if (num > MAXVAL) fail(ERR_PIXEL);
              else give_component(num[7:0]);
            end else begin
              fail(ERR_EARLY_END);
            end
          end
          default: fail(ERR_EARLY_END);
        endcase
        rearm();
      end else begin
        case (phase)
          WANT_P: begin
            if (b != CH_P) fail(ERR_NO_MAGIC);
            else phase = WANT_FORMAT;
          end
          WANT_FORMAT: begin
            if (b == CH_3 || b == CH_6) begin
              raw_fmt = (b == CH_6);
              phase = IN_HEADER;
            end else begin
              fail(ERR_NO_MAGIC);
            end
          end
          IN_HEADER: begin
            if (in_cmt) begin
              // comment end also terminates a number cut by the comment
              if (b == CH_LF || b == CH_CR) begin
                in_cmt = 1'b0;
                if (have_digits) close_header_number();
              end
            end else if (b == CH_HASH) begin
              in_cmt = 1'b1;
            end else if (is_num(b)) begin
              num = num * 10 + (b - CH_0);
              have_digits = 1'b1;
              if (num > DIM_MAX) fail(ERR_TOO_BIG);
            end else if (is_blank(b)) begin
              if (have_digits) close_header_number();
            end else begin
              fail(ERR_BAD_CHAR);
            end
          end
          RAW_DATA: give_component(b);
          PLAIN_DATA: begin
            if (is_num(b)) begin
              num = num * 10 + (b - CH_0);
              have_digits = 1'b1;
              if (num > DIM_MAX) fail(ERR_PIXEL);
            end else if (is_blank(b)) begin
              if (have_digits) begin
                v = num;
                num = '0;
                have_digits = 1'b0;
                if (v > MAXVAL) fail(ERR_PIXEL);
                else give_component(v[7:0]);
              end
            end else begin
              fail(ERR_BAD_CHAR);
            end
          end
          default: ;
        endcase
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // One accepted output transaction.
    function void check_result(logic [1:0] kind, logic [47:0] data, logic lst);
      result_t want;
      if (results_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none %s",
                 $time, $sformatf("actual kind %0h data %h last %0b", kind, data, lst));
        errors++;
      end else begin
        want = results_due.pop_front();
        compare_field("kind", 16'(want.kind), 16'(kind));
        compare_field("component", 16'(want.component), 16'(data[7:0]));
        compare_field("image_cols", want.image_cols, data[23:8]);
        compare_field("image_rows", want.image_rows, data[39:24]);
        compare_field("error_code", 16'(want.error_code), 16'(data[42:40]));
        compare_field("padding", 16'd0, 16'(data[47:43]));
        compare_field("last", 16'(want.last), 16'(lst));
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'd0;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  parse_scoreboard sb = new();
  logic [7:0]      file_q[$];
  int unsigned     cycles     = 0;
  int unsigned     gap_odds   = 3;
  int unsigned     stall_odds = 3;
  bit              calm       = 1'b0;

  ppm_stream_parser_unit #(.DIM_BITS(DIM_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ppm_stream_parser_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
  end

  // receiver back-pressure in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(0, 5))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic void append_str(string s);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endfunction

  function automatic void append_comment();
    logic [7:0] b;
    file_q.push_back(CH_HASH);
    repeat ($urandom_range(0, 4)) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_LF || b == CH_CR) b = b ^ 8'h80;
      file_q.push_back(b);
    end
    file_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
  endfunction

  function automatic void append_sep(bit with_comments);
    repeat ($urandom_range(1, 3)) begin
      if (with_comments && $urandom_range(0, 5) == 0) append_comment();
      else file_q.push_back(pick_ws());
    end
  endfunction

  function automatic void append_number(longint unsigned v, bit with_comments);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) file_q.push_back(CH_0);
    for (int i = 0; i < s.len(); i++) begin
      file_q.push_back(s[i]);
      if (with_comments && i + 1 < s.len() && $urandom_range(0, 15) == 0) append_comment();
    end
  endfunction

  // Mostly well-formed P3/P6 files with random content; some damaged or cut short.
  function automatic void build_file();
    longint unsigned cols, rows, maxv, count, v;
    int unsigned     flavor, pos, cut;
    logic            raw;
    raw    = 1'($urandom_range(0, 1));
    flavor = $urandom_range(0, 99);
    maxv   = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 999) : 255;
    case ($urandom_range(0, 23))
      0: begin cols = 65535; rows = 0; end
      1: begin cols = 0; rows = $urandom_range(0, 65535); end
      2: begin cols = $urandom_range(1, 65535); rows = 65535; end
      3: begin cols = $urandom_range(65536, 999999); rows = 1; end
      4: begin cols = $urandom_range(1, 3); rows = 0; end
      default: begin cols = $urandom_range(1, 3); rows = $urandom_range(1, 2); end
    endcase
    count = 3 * cols * rows;
    // huge images are only started, then cut off by the end mark
    if (count > 18) count = $urandom_range(0, 6);
    file_q.push_back(CH_P);
    file_q.push_back(raw ? CH_6 : CH_3);
    if ($urandom_range(0, 3) != 0) append_sep(1'b1);
    append_number(cols, 1'b1);
    append_sep(1'b1);
    append_number(rows, 1'b1);
    append_sep(1'b1);
    append_number(maxv, 1'b1);
    if (count != 0 || $urandom_range(0, 1)) file_q.push_back(pick_ws());
    for (longint unsigned i = 0; i < count; i++) begin
      if (raw) begin
        file_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 49))
          0:       v = $urandom_range(65536, 999999);
          1, 2:    v = $urandom_range(256, 65535);
          default: v = $urandom_range(0, 255);
        endcase
        append_number(v, 1'b0);
        if (i + 1 < count || $urandom_range(0, 1)) append_sep(1'b0);
      end
    end
    if (flavor < 12) begin
      pos = $urandom_range(0, file_q.size() - 1);
      file_q[pos] = 8'($urandom_range(0, 255));
    end else if (flavor < 22) begin
      cut = $urandom_range(0, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else if (flavor < 30) begin
      repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom_range(0, 255)));
    end else if (flavor == 99) begin
      file_q.delete();
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eom);
    @(negedge clk);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = eom;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b, eom);
  endtask

  // every byte of file_q, then the end-mark transaction
  task automatic send_file();
    foreach (file_q[i]) send_item(file_q[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    file_q.delete();
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.results_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned sent;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // end mark right at the start of a file
    send_file();
    // digit right after the magic; end mark completes maxval of an empty image
    append_str("P61 0 255");
    send_file();
    // comment closed by CR, raw extremes, trailing bytes ignored
    append_str("P6 1 1 #c");
    file_q.push_back(CH_CR);
    append_str("255\n");
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h80);
    append_str("zz");
    send_file();
    // last plain value finished by the end mark
    append_str("P3 1 1 255 0 0 255");
    send_file();
    // bad character ending an out-of-range value
    append_str("P3 1 1 255 300#");
    send_file();
    append_str("P5");
    send_file();
    append_str("P3 1 1 254 ");
    send_file();
    append_str("P6 65536");
    send_file();
    append_str("P3 1 1 2x");
    send_file();
    // pixel count needs the full 34 bits; file ends early
    append_str("P6 65535 65535 255 ab");
    send_file();
    drain();

    while (sent < RANDOM_ITEMS) begin
      build_file();
      sent += file_q.size() + 1;
      case ($urandom_range(0, 3))
        0: gap_odds = 0;
        1: gap_odds = 2;
        2: gap_odds = 5;
        default: gap_odds = 12;
      endcase
      case ($urandom_range(0, 3))
        0: stall_odds = 0;
        1: stall_odds = 2;
        2: stall_odds = 5;
        default: stall_odds = 12;
      endcase
      calm = sent > RANDOM_ITEMS * 4 / 5;
      send_file();
      if (!paused && sent > RANDOM_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("ppm_stream_parser_unit verification clean");
    end else begin
      $display("ppm_stream_parser_unit verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ppsp_pkg.sv
rtl/ppsp_front.sv
rtl/ppsp_queue.sv
rtl/ppsp_back.sv
rtl/ppm_stream_parser_unit.sv
bench/ppm_stream_parser_unit_tb.sv
